[rtl/gto_pkg.sv]
// gto_pkg: shared constants and types for the graph traversal engine
// depends on nothing
package gto_pkg;

  localparam int MaxVertices = 64;
  localparam int MaxDegree   = 16;
  localparam int VtxW        = 6;
  localparam int CntW        = 7;
  localparam int DegW        = 5;
  localparam int PosW        = 4;
  localparam int AdjAw       = VtxW + PosW;

  typedef enum logic [1:0] {
    CMD_ADD_VERTEX = 2'd0,
    CMD_ADD_EDGE   = 2'd1,
    CMD_BFS        = 2'd2,
    CMD_DFS        = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TABLE_FULL = 3'd1,
    ST_UNKNOWN    = 3'd2,
    ST_SELF       = 3'd3,
    ST_LIST_FULL  = 3'd4,
    ST_EMPTY      = 3'd5
  } status_t;

endpackage

[rtl/graph_traversal_order.sv]
// graph_traversal_order: graph store with breadth-first and depth-first walks
// depends on gto_pkg
//
//  channel | handshake             | fields                                   | beat
//  in      | in_valid, in_stall    | in_command in_source_vertex              | one command
//          |                       | in_target_vertex                         |
//  out     | out_valid, out_stall  | out_visited_vertex out_status            | one result
//          |                       | out_last_result                          |
//
// one command at a time; input stalls until the command has put out its last result.
// add vertex: result in the cycle after acceptance; add edge: degree read, then check.
// traversal: clear the mark of each vertex, scan start vertices by reading their marks,
// visit each reached vertex, read each adjacency entry and the mark it names, pop back
// to a parent on a depth-first return, then put out the last result.
// reset clears state, vertex count, degree valid bits, result valid and pending flag only.
// a result held under out_stall holds the walk at its next visit or its last result.
module graph_traversal_order (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_command,
  input  logic [gto_pkg::VtxW-1:0]  in_source_vertex,
  input  logic [gto_pkg::VtxW-1:0]  in_target_vertex,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gto_pkg::VtxW-1:0]  out_visited_vertex,
  output logic [2:0]                out_status,
  output logic                      out_last_result
);

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_CHK, S_CLEAR, S_SCAN, S_SCAN_GOT, S_CUR, S_CUR_GOT,
    S_ADJ_RD, S_ADJ_GOT, S_VIS_GOT, S_VISIT, S_LAST
  } state_t;

  // memories
  logic [gto_pkg::VtxW-1:0] adj_mem [gto_pkg::MaxVertices*gto_pkg::MaxDegree];
  logic [gto_pkg::DegW-1:0] deg_mem [gto_pkg::MaxVertices];
  logic [gto_pkg::VtxW-1:0] work_mem [gto_pkg::MaxVertices];
  logic [gto_pkg::DegW-1:0] pos_mem [gto_pkg::MaxVertices];
  logic                     vis_mem [gto_pkg::MaxVertices];

  state_t                          state_r, state_nxt;
  logic [gto_pkg::CntW-1:0]        vcount_r, vcount_nxt;
  logic [gto_pkg::MaxVertices-1:0] deg_ok_r, deg_ok_nxt;
  logic                            dfs_r;
  logic [gto_pkg::VtxW-1:0]        src_r, dst_r;
  logic [gto_pkg::CntW-1:0]        scan_r, scan_nxt;   // next start vertex
  logic [gto_pkg::CntW-1:0]        head_r, head_nxt;   // bfs queue head
  logic [gto_pkg::CntW-1:0]        tail_r, tail_nxt;   // bfs queue tail / dfs stack top
  logic [gto_pkg::VtxW-1:0]        cur_r, cur_nxt;
  logic [gto_pkg::VtxW-1:0]        nv_r, nv_nxt;       // vertex about to be visited
  logic [gto_pkg::DegW-1:0]        pos_r, pos_nxt;
  logic                            start_r, start_nxt; // visit starts a new walk
  logic                            pend_r, pend_nxt;   // result held back to learn last flag
  logic [gto_pkg::VtxW-1:0]        pend_v_r, pend_v_nxt;
  logic                            ov_r, ov_nxt;
  logic [gto_pkg::VtxW-1:0]        ov_v_r, ov_v_nxt;
  gto_pkg::status_t                ov_s_r, ov_s_nxt;
  logic                            ov_l_r, ov_l_nxt;

  logic [gto_pkg::DegW-1:0] deg_q, pos_q;
  logic [gto_pkg::VtxW-1:0] adj_q, work_q;
  logic                     vis_q;

  // memory ports
  logic                      adj_we, deg_we, work_we, pos_we, vis_we;
  logic [gto_pkg::AdjAw-1:0] adj_wa, adj_ra;
  logic [gto_pkg::VtxW-1:0]  adj_wd, deg_ra, deg_wa, work_ra, work_wa, work_wd;
  logic [gto_pkg::VtxW-1:0]  pos_ra, pos_wa, vis_ra, vis_wa;
  logic [gto_pkg::DegW-1:0]  deg_wd, pos_wd;
  logic                      vis_wd;

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    adj_q <= adj_mem[adj_ra];
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_q <= deg_mem[deg_ra];
    if (work_we) work_mem[work_wa] <= work_wd;
    work_q <= work_mem[work_ra];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q <= pos_mem[pos_ra];
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  logic             out_free, in_acc;
  gto_pkg::cmd_t    in_cmd;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_acc = in_valid && !in_stall;
  assign in_cmd = gto_pkg::cmd_t'(in_command);
  assign out_valid = ov_r;
  assign out_visited_vertex = ov_v_r;
  assign out_status = ov_s_r;
  assign out_last_result = ov_l_r;

  // degrees with never-written lists read as zero
  logic [gto_pkg::DegW-1:0] deg_src, deg_cur;
  logic [gto_pkg::CntW-1:0] tail_m1;
  assign deg_src = deg_ok_r[src_r] ? deg_q : '0;
  assign deg_cur = deg_ok_r[cur_r] ? deg_q : '0;
  assign tail_m1 = tail_r - gto_pkg::CntW'(1);

  // next-state and datapath
  always_comb begin
    state_nxt = state_r; vcount_nxt = vcount_r; deg_ok_nxt = deg_ok_r;
    scan_nxt = scan_r; head_nxt = head_r; tail_nxt = tail_r;
    cur_nxt = cur_r; nv_nxt = nv_r; pos_nxt = pos_r; start_nxt = start_r;
    pend_nxt = pend_r; pend_v_nxt = pend_v_r;
    ov_nxt = ov_r && out_stall; ov_v_nxt = ov_v_r; ov_s_nxt = ov_s_r;
    ov_l_nxt = ov_l_r;
    adj_we = 1'b0; deg_we = 1'b0; work_we = 1'b0; pos_we = 1'b0; vis_we = 1'b0;
    adj_wa = {src_r, deg_src[gto_pkg::PosW-1:0]}; adj_wd = dst_r;
    adj_ra = {cur_r, pos_r[gto_pkg::PosW-1:0]};
    deg_ra = cur_r; deg_wa = src_r; deg_wd = deg_src + gto_pkg::DegW'(1);
    work_ra = dfs_r ? tail_m1[gto_pkg::VtxW-1:0] : head_r[gto_pkg::VtxW-1:0];
    work_wa = tail_r[gto_pkg::VtxW-1:0]; work_wd = nv_r;
    pos_ra = work_ra; pos_wa = tail_r[gto_pkg::VtxW-1:0]; pos_wd = '0;
    vis_ra = scan_r[gto_pkg::VtxW-1:0]; vis_wa = nv_r; vis_wd = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && out_free) begin
          unique case (in_cmd) inside
            gto_pkg::CMD_ADD_VERTEX: begin
              ov_nxt = 1'b1; ov_l_nxt = 1'b1;
              if (vcount_r >= gto_pkg::CntW'(gto_pkg::MaxVertices)) begin
                ov_v_nxt = '0; ov_s_nxt = gto_pkg::ST_TABLE_FULL;
              end else begin
                ov_v_nxt = vcount_r[gto_pkg::VtxW-1:0]; ov_s_nxt = gto_pkg::ST_OK;
                deg_ok_nxt[vcount_r[gto_pkg::VtxW-1:0]] = 1'b0;
                vcount_nxt = vcount_r + gto_pkg::CntW'(1);
              end
            end
            gto_pkg::CMD_ADD_EDGE: begin
              deg_ra = in_source_vertex;
              state_nxt = S_EDGE_CHK;
            end
            gto_pkg::CMD_BFS, gto_pkg::CMD_DFS: begin
              if (vcount_r == '0) begin
                ov_nxt = 1'b1; ov_l_nxt = 1'b1; ov_v_nxt = '0;
                ov_s_nxt = gto_pkg::ST_EMPTY;
              end else begin
                scan_nxt = '0;
                state_nxt = S_CLEAR;
              end
            end
          endcase
        end
      end
      // check the edge and append it to the source list
      S_EDGE_CHK: begin
        if (out_free) begin
          ov_nxt = 1'b1; ov_l_nxt = 1'b1; ov_v_nxt = '0;
          if ({1'b0, src_r} >= vcount_r || {1'b0, dst_r} >= vcount_r)
            ov_s_nxt = gto_pkg::ST_UNKNOWN;
          else if (src_r == dst_r) ov_s_nxt = gto_pkg::ST_SELF;
          else if (deg_src >= gto_pkg::DegW'(gto_pkg::MaxDegree))
            ov_s_nxt = gto_pkg::ST_LIST_FULL;
          else begin
            ov_s_nxt = gto_pkg::ST_OK; adj_we = 1'b1; deg_we = 1'b1;
            deg_ok_nxt[src_r] = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      // clear visited marks of all known vertices
      S_CLEAR: begin
        vis_we = 1'b1; vis_wa = scan_r[gto_pkg::VtxW-1:0]; vis_wd = 1'b0;
        if (scan_r + gto_pkg::CntW'(1) >= vcount_r) begin
          scan_nxt = '0; pend_nxt = 1'b0; state_nxt = S_SCAN;
        end else begin
          scan_nxt = scan_r + gto_pkg::CntW'(1);
        end
      end
      // read the mark of the next start vertex, or finish once all are scanned
      S_SCAN: begin
        if (scan_r >= vcount_r) state_nxt = S_LAST;
        else state_nxt = S_SCAN_GOT;
      end
      S_SCAN_GOT: begin
        if (vis_q) begin
          scan_nxt = scan_r + gto_pkg::CntW'(1); state_nxt = S_SCAN;
        end else begin
          nv_nxt = scan_r[gto_pkg::VtxW-1:0]; head_nxt = '0; tail_nxt = '0;
          start_nxt = 1'b1; state_nxt = S_VISIT;
        end
      end
      // mark and push a newly reached vertex, report the one held before it
      S_VISIT: begin
        if (out_free) begin
          if (pend_r) begin
            ov_nxt = 1'b1; ov_v_nxt = pend_v_r; ov_s_nxt = gto_pkg::ST_OK;
            ov_l_nxt = 1'b0;
          end
          pend_nxt = 1'b1; pend_v_nxt = nv_r;
          vis_we = 1'b1; work_we = 1'b1; pos_we = 1'b1;
          tail_nxt = tail_r + gto_pkg::CntW'(1);
          start_nxt = 1'b0;
          state_nxt = (start_r || dfs_r) ? S_CUR : S_ADJ_RD;
        end
      end
      // pick current vertex: queue head or stack top
      S_CUR: begin
        if (dfs_r ? (tail_r == '0) : (head_r == tail_r)) begin
          scan_nxt = scan_r + gto_pkg::CntW'(1); state_nxt = S_SCAN;
        end else begin
          if (!dfs_r) head_nxt = head_r + gto_pkg::CntW'(1);
          state_nxt = S_CUR_GOT;
        end
      end
      S_CUR_GOT: begin
        cur_nxt = work_q; pos_nxt = dfs_r ? pos_q : '0;
        state_nxt = S_ADJ_RD;
      end
      // degree of current vertex and adjacency entry at pos
      S_ADJ_RD: state_nxt = S_ADJ_GOT;
      S_ADJ_GOT: begin
        if (pos_r < deg_cur) begin
          nv_nxt = adj_q; vis_ra = adj_q;
          pos_nxt = pos_r + gto_pkg::DegW'(1);
          if (dfs_r) begin
            pos_we = 1'b1; pos_wa = tail_m1[gto_pkg::VtxW-1:0]; pos_wd = pos_nxt;
          end
          state_nxt = S_VIS_GOT;
        end else begin
          if (dfs_r) tail_nxt = tail_m1;
          state_nxt = S_CUR;
        end
      end
      S_VIS_GOT: state_nxt = vis_q ? S_ADJ_RD : S_VISIT;
      // flush the held result as the last one
      S_LAST: begin
        if (out_free) begin
          ov_nxt = 1'b1; ov_v_nxt = pend_v_r; ov_s_nxt = gto_pkg::ST_OK;
          ov_l_nxt = 1'b1; pend_nxt = 1'b0; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; vcount_r <= '0; deg_ok_r <= '0;
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; vcount_r <= vcount_nxt; deg_ok_r <= deg_ok_nxt;
      ov_r <= ov_nxt; pend_r <= pend_nxt;
    end
    if (in_acc) begin
      src_r <= in_source_vertex; dst_r <= in_target_vertex;
      dfs_r <= (in_cmd == gto_pkg::CMD_DFS);
    end
    scan_r <= scan_nxt; head_r <= head_nxt; tail_r <= tail_nxt;
    cur_r <= cur_nxt; nv_r <= nv_nxt; pos_r <= pos_nxt; start_r <= start_nxt;
    pend_v_r <= pend_v_nxt; ov_v_r <= ov_v_nxt; ov_s_r <= ov_s_nxt;
    ov_l_r <= ov_l_nxt;
  end

endmodule

[rtl/gto_checker.sv]
// gto_sva: port-level assertions for graph_traversal_order
// depends on gto_pkg; bound to the top level below
module gto_sva (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [2:0]               out_status,
  input logic                     out_last_result,
  input logic [gto_pkg::VtxW-1:0] out_visited_vertex
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visited_vertex) &&
    $stable(out_status) && $stable(out_last_result))
    else $error("result beat changed under stall");

  // error statuses only ever end a command
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gto_pkg::ST_OK |-> out_last_result)
    else $error("error status not final");

  // error results carry vertex zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != gto_pkg::ST_OK |-> out_visited_vertex == '0)
    else $error("error result with nonzero vertex");

  // reset leaves no result valid
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind graph_traversal_order gto_sva u_gto_sva (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_last_result(out_last_result), .out_visited_vertex(out_visited_vertex)
);
